[rtl/shabsh_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher: shared package
// Types, sequencer states, round constants and the initial vector.
// ----------------------------------------------------------------------------
`default_nettype none

package shabsh_pkg;

  typedef logic [7:0]        byte_t;
  typedef logic [31:0]       word_t;
  typedef logic [2:0]        widx_t;
  typedef logic [5:0]        ridx_t;
  // Eight working or chaining words; index 0 is word a / H0.
  typedef logic [7:0][31:0]  chain_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PH_MARK,
    PH_ZERO,
    PH_LEN,
    PH_DONE
  } pad_phase_t;

  // Control from the sequencer to the round unit.
  typedef struct packed {
    logic  push;
    byte_t data;
    logic  load;
    logic  step;
    ridx_t round;
  } rnd_ctrl_t;

  localparam byte_t PAD_BYTE   = 8'h80;
  localparam ridx_t LEN_POS    = 6'd56;
  localparam ridx_t BLOCK_LAST = 6'd63;
  localparam ridx_t ROUND_LAST = 6'd63;
  localparam widx_t WORD_LAST  = 3'd7;

  localparam chain_t INIT_VEC = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

`default_nettype wire

[rtl/shabsh_if.sv]
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher: channel interfaces
// Valid/ready channels for message bytes and for digest words.
// ----------------------------------------------------------------------------
`default_nettype none

interface shabsh_in_if import shabsh_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  byte_present;
  logic  end_of_message;

  modport source (output valid, output data_byte, output byte_present,
                  output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input byte_present,
                  input end_of_message, output ready);
endinterface

interface shabsh_out_if import shabsh_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t digest_word;
  widx_t word_index;
  logic  last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

`default_nettype wire

[rtl/sha256_byte_stream_hasher.sv]
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Absorbs a message one byte per request and returns its SHA-256 digest.
// ----------------------------------------------------------------------------
// Usage. The input channel in_ch takes one request per message byte:
// data_byte is absorbed when byte_present is high, and end_of_message closes
// the message after that byte (a request with no byte and end_of_message set
// finalises the message as it stands, which covers the empty message).
// The output channel out_ch then returns the digest as eight 32-bit words,
// most significant first, with word_index 0 to 7 and last_word on the eighth.
// Timing. Every 64th byte starts the compression: 64 rounds in the single
// shared round unit, one round a cycle, then a fold of the result into the
// chaining words. in_ch.ready is low during compression, padding and digest
// output. Finalisation pushes the pad, zero fill and length one byte a cycle
// (up to 72 bytes) with one or two compressions, then presents the words.
// Digest words come straight from the chaining registers; if the receiver
// stalls, a word simply holds until taken. After the eighth word the block
// returns to the initial vector.
// Reset (rst_n low, synchronous) restores the initial vector, clears the
// length and fill count and leaves the block idle and ready.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_byte_stream_hasher import shabsh_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  shabsh_in_if.sink     in_ch,
  shabsh_out_if.source  out_ch
);

  state_t     state_r, state_nxt;
  pad_phase_t phase_r, phase_nxt;
  ridx_t      fill_r, fill_nxt;       // bytes held in the current block
  ridx_t      round_r, round_nxt;
  widx_t      len_idx_r, len_idx_nxt; // next length byte during padding
  widx_t      emit_idx_r, emit_idx_nxt;
  logic       fin_r, fin_nxt;         // finalising the current message
  logic [63:0] bits_r, bits_nxt;      // message length in bits, modulo 2^64
  chain_t     chain_r, chain_nxt;

  chain_t     work;
  rnd_ctrl_t  rctl;
  ridx_t      fill_inc;
  byte_t      pad_byte;
  logic       in_acc, out_acc;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_acc     = out_ch.valid && out_ch.ready;
  assign fill_inc    = fill_r + 6'd1;

  // The length goes out big-endian: byte 0 is bits 63:56.
  always_comb begin
    case (phase_r)
      PH_MARK: pad_byte = PAD_BYTE;
      PH_LEN:  pad_byte = bits_r[{~len_idx_r, 3'b000} +: 8];
      default: pad_byte = 8'h00;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.byte_present && fill_r == BLOCK_LAST) begin
            state_nxt = ST_ROUND;
          end else if (in_ch.end_of_message) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        if (round_r == ROUND_LAST) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (!fin_r) begin
          state_nxt = ST_IDLE;
        end else if (phase_r == PH_DONE) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_PAD;
        end
      end
      ST_PAD: begin
        if (fill_r == BLOCK_LAST) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_EMIT: begin
        if (out_acc && emit_idx_r == WORD_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath control and counters.
  always_comb begin
    phase_nxt    = phase_r;
    fill_nxt     = fill_r;
    round_nxt    = round_r;
    len_idx_nxt  = len_idx_r;
    emit_idx_nxt = emit_idx_r;
    fin_nxt      = fin_r;
    bits_nxt     = bits_r;
    chain_nxt    = chain_r;
    rctl         = '0;
    rctl.round   = round_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          fin_nxt      = in_ch.end_of_message;
          phase_nxt    = PH_MARK;
          len_idx_nxt  = '0;
          emit_idx_nxt = '0;
          round_nxt    = '0;
          if (in_ch.byte_present) begin
            rctl.push = 1'b1;
            rctl.data = in_ch.data_byte;
            rctl.load = (fill_r == BLOCK_LAST);
            fill_nxt  = fill_inc;
            bits_nxt  = bits_r + 64'd8;
          end
        end
      end
      ST_ROUND: begin
        rctl.step = 1'b1;
        round_nxt = round_r + 6'd1;
      end
      ST_FOLD: begin
        for (int i = 0; i < 8; i++) begin
          chain_nxt[i] = chain_r[i] + work[i];
        end
      end
      ST_PAD: begin
        rctl.push = 1'b1;
        rctl.data = pad_byte;
        rctl.load = (fill_r == BLOCK_LAST);
        fill_nxt  = fill_inc;
        round_nxt = '0;
        case (phase_r)
          PH_MARK, PH_ZERO: begin
            phase_nxt = (fill_inc == LEN_POS) ? PH_LEN : PH_ZERO;
          end
          PH_LEN: begin
            len_idx_nxt = len_idx_r + 3'd1;
            if (len_idx_r == WORD_LAST) begin
              phase_nxt = PH_DONE;
            end
          end
          default: phase_nxt = phase_r;
        endcase
      end
      ST_EMIT: begin
        if (out_acc) begin
          emit_idx_nxt = emit_idx_r + 3'd1;
          if (emit_idx_r == WORD_LAST) begin
            chain_nxt = INIT_VEC;
            fill_nxt  = '0;
            bits_nxt  = '0;
            fin_nxt   = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      phase_r    <= PH_MARK;
      fill_r     <= '0;
      round_r    <= '0;
      len_idx_r  <= '0;
      emit_idx_r <= '0;
      fin_r      <= 1'b0;
      bits_r     <= '0;
      chain_r    <= INIT_VEC;
    end else begin
      state_r    <= state_nxt;
      phase_r    <= phase_nxt;
      fill_r     <= fill_nxt;
      round_r    <= round_nxt;
      len_idx_r  <= len_idx_nxt;
      emit_idx_r <= emit_idx_nxt;
      fin_r      <= fin_nxt;
      bits_r     <= bits_nxt;
      chain_r    <= chain_nxt;
    end
  end

  shabsh_round u_round (
    .clk   (clk),
    .ctrl  (rctl),
    .chain (chain_r),
    .work  (work)
  );

  assign out_ch.valid       = (state_r == ST_EMIT);
  assign out_ch.digest_word = chain_r[emit_idx_r];
  assign out_ch.word_index  = emit_idx_r;
  assign out_ch.last_word   = (emit_idx_r == WORD_LAST);

  // The length field always ends a block, so digest output starts on an empty block.
  a_emit_block_empty : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> fill_r == '0)
    else $error("digest presented with a partly filled block");

  // Taking the last digest word restarts the chain and the length count.
  a_restart : assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.last_word)
      |=> (chain_r == INIT_VEC && bits_r == '0 && in_ch.ready))
    else $error("block did not return to the initial vector");

  // The 64th byte of a block always starts the compression rounds.
  a_block_full : assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.byte_present && fill_r == BLOCK_LAST)
      |=> (state_r == ST_ROUND && round_r == '0))
    else $error("full block did not start compression");

  // After the last round the result is folded into the chain.
  a_fold : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && round_r == ROUND_LAST) |=> state_r == ST_FOLD)
    else $error("compression did not end in a fold");

endmodule

`default_nettype wire

[rtl/shabsh_round.sv]
// ----------------------------------------------------------------------------
// SHA-256 round unit
// Holds the 16-word schedule window, which doubles as the byte block, and
// the eight working words; performs one compression round per step.
// ----------------------------------------------------------------------------
`default_nettype none

module shabsh_round import shabsh_pkg::*; (
  input  wire logic      clk,
  input  wire rnd_ctrl_t ctrl,
  input  wire chain_t    chain,
  output chain_t         work
);

  // Word 15 is the oldest (W[t-16], also the round word W[t]); word 0 the newest.
  logic [15:0][31:0] window_r, window_nxt;
  chain_t            work_r, work_nxt;

  word_t w_new, t1, t2;
  word_t a, b, c, d, e, f, g, h;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  assign a = work_r[0];
  assign b = work_r[1];
  assign c = work_r[2];
  assign d = work_r[3];
  assign e = work_r[4];
  assign f = work_r[5];
  assign g = work_r[6];
  assign h = work_r[7];

  always_comb begin
    w_new = window_r[15]
          + (rotr(window_r[14], 7) ^ rotr(window_r[14], 18) ^ (window_r[14] >> 3))
          + window_r[6]
          + (rotr(window_r[1], 17) ^ rotr(window_r[1], 19) ^ (window_r[1] >> 10));
    t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
       + ROUND_K[ctrl.round] + window_r[15];
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
  end

  always_comb begin
    window_nxt = window_r;
    work_nxt   = work_r;
    if (ctrl.push) begin
      // The whole window moves up by one byte; the top byte falls out.
      window_nxt = {window_r[15][23:0], window_r[14:0], ctrl.data};
    end else if (ctrl.step) begin
      window_nxt = {window_r[14:0], w_new};
    end
    if (ctrl.load) begin
      work_nxt = chain;
    end else if (ctrl.step) begin
      work_nxt = {g, f, e, d + t1, c, b, a, t1 + t2};
    end
  end

  always_ff @(posedge clk) begin
    window_r <= window_nxt;
    work_r   <= work_nxt;
  end

  assign work = work_r;

endmodule

`default_nettype wire

[tb/sha256_byte_stream_hasher_tb.sv]
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher: self-checking testbench
// Byte requests are offered from a queue of pending requests, and each
// accepted request is run through a behavioural SHA-256 kept in the bench.
// That model predicts the eight digest words that each end-of-message request
// must produce. Every returned word is checked field by field against the
// oldest prediction. Both channels idle at random. The receiver holds off for
// one long stretch, and the sender now and then waits for all words to drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sha256_byte_stream_hasher_tb import shabsh_pkg::*; ();

  localparam int unsigned HALF_PERIOD       = 6;
  localparam int unsigned RESET_CYCLES      = 12;
  localparam int unsigned MESSAGE_REQS      = 380;
  // Requests left in the queue once the run enters its last stretch; from
  // then on neither side idles.
  localparam int unsigned TAIL_REQS         = 60;
  localparam int unsigned LONG_STALL_CYCLES = 400;
  // Worst case after the last request: pad and length (72 bytes), two
  // compressions and eight words. Rounded up generously.
  localparam int unsigned SETTLE_CYCLES     = 300;

  // SHA-256 round constants and initial hash value (FIPS 180-4).
  localparam word_t K_TABLE [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t IV_WORDS [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam byte_t MARK_BYTE = 8'h80;
  localparam int unsigned LEN_OFFSET  = 56;
  localparam int unsigned BLOCK_BYTES = 64;

  // One request on the byte channel. hold_for_drain makes the sender wait,
  // before offering this request, until every predicted word has arrived.
  typedef struct {
    byte_t data_byte;
    logic  byte_present;
    logic  end_of_message;
    logic  hold_for_drain;
  } hash_req_t;

  typedef struct packed {
    word_t digest_word;
    widx_t word_index;
    logic  last_word;
  } digest_exp_t;

  logic clk;
  logic rst_n;

  shabsh_in_if  in_ch ();
  shabsh_out_if out_ch ();

  sha256_byte_stream_hasher u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Stimulus and expectations.
  hash_req_t   pending_reqs [$];
  digest_exp_t digest_words_due [$];
  hash_req_t   req_on_wire;
  int unsigned msg_reqs_queued;
  int unsigned mismatches;
  int unsigned digests_checked;

  // Hash state of the behavioural model.
  word_t       chain_h [8];
  byte_t       msg_block [64];
  int unsigned block_fill;
  logic [63:0] msg_bits;

  // Idle and stall bookkeeping.
  int unsigned send_gap_left;
  int unsigned recv_gap_left;
  int unsigned long_stall_left;
  logic        long_stall_done;

  initial begin
    clk = 1'b0;
    forever #(HALF_PERIOD) clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Behavioural SHA-256
  // --------------------------------------------------------------------------

  function automatic word_t rotr32(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Runs the 64 rounds over the current block and folds the working words
  // back into the chaining words.
  function automatic void sha_compress_block();
    word_t sched [64];
    word_t wv [8];
    word_t s0, s1, t1, t2, choose, major;
    int unsigned i;
    for (i = 0; i < 16; i++)
      sched[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (i = 16; i < 64; i++) begin
      s0 = rotr32(sched[i-15], 7) ^ rotr32(sched[i-15], 18) ^ (sched[i-15] >> 3);
      s1 = rotr32(sched[i-2], 17) ^ rotr32(sched[i-2], 19) ^ (sched[i-2] >> 10);
      sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
    end
    for (i = 0; i < 8; i++)
      wv[i] = chain_h[i];
    for (i = 0; i < 64; i++) begin
      s1     = rotr32(wv[4], 6) ^ rotr32(wv[4], 11) ^ rotr32(wv[4], 25);
      choose = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
      t1     = wv[7] + s1 + choose + K_TABLE[i] + sched[i];
      s0     = rotr32(wv[0], 2) ^ rotr32(wv[0], 13) ^ rotr32(wv[0], 22);
      major  = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
      t2     = s0 + major;
      wv[7] = wv[6];
      wv[6] = wv[5];
      wv[5] = wv[4];
      wv[4] = wv[3] + t1;
      wv[3] = wv[2];
      wv[2] = wv[1];
      wv[1] = wv[0];
      wv[0] = t1 + t2;
    end
    for (i = 0; i < 8; i++)
      chain_h[i] = chain_h[i] + wv[i];
  endfunction

  // Places one byte in the block and compresses once the block is full.
  function automatic void sha_take_byte(byte_t b);
    msg_block[block_fill] = b;
    block_fill++;
    if (block_fill == BLOCK_BYTES) begin
      sha_compress_block();
      block_fill = 0;
    end
  endfunction

  function automatic void sha_restart();
    int unsigned i;
    for (i = 0; i < 8; i++)
      chain_h[i] = IV_WORDS[i];
    block_fill = 0;
    msg_bits   = '0;
  endfunction

  // Applies one accepted request to the model. A byte, when present, is
  // absorbed before the message is closed. Closing pads with the mark byte,
  // zero fills to the length field, appends the big-endian bit count and then
  // queues the eight digest words, most significant first.
  function automatic void sha_absorb_request(hash_req_t req);
    logic [63:0] len_snapshot;
    int unsigned i;
    digest_exp_t exp_word;
    if (req.byte_present) begin
      sha_take_byte(req.data_byte);
      msg_bits = msg_bits + 64'd8;
    end
    if (req.end_of_message) begin
      len_snapshot = msg_bits;
      sha_take_byte(MARK_BYTE);
      while (block_fill != LEN_OFFSET)
        sha_take_byte(8'h00);
      for (i = 0; i < 8; i++)
        sha_take_byte(len_snapshot[63 - 8*i -: 8]);
      for (i = 0; i < 8; i++) begin
        exp_word.digest_word = chain_h[i];
        exp_word.word_index  = widx_t'(i);
        exp_word.last_word   = (i == 7);
        digest_words_due = {digest_words_due, exp_word};
      end
      sha_restart();
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus construction
  // --------------------------------------------------------------------------

  // Only requests that carry a byte or close a message count towards the
  // size of the run; a request with neither is ignored by the block.
  function automatic void queue_req(byte_t d, logic present, logic eom, logic drain);
    hash_req_t req;
    req.data_byte      = d;
    req.byte_present   = present;
    req.end_of_message = eom;
    req.hold_for_drain = drain;
    pending_reqs = {pending_reqs, req};
    if (present || eom)
      msg_reqs_queued++;
  endfunction

  // A message of random content. Now and then an empty request is slipped in
  // between bytes, and the message is closed either on its last byte or by a
  // separate end request that carries no byte.
  function automatic void queue_message(int unsigned n_bytes, logic drain);
    int unsigned k;
    logic end_on_byte;
    logic first;
    end_on_byte = (n_bytes != 0) && ($urandom_range(0, 1) == 1);
    first = drain;
    for (k = 0; k < n_bytes; k++) begin
      if ($urandom_range(0, 15) == 0) begin
        queue_req(byte_t'($urandom_range(0, 255)), 1'b0, 1'b0, first);
        first = 1'b0;
      end
      queue_req(byte_t'($urandom_range(0, 255)), 1'b1,
                end_on_byte && (k == n_bytes - 1), first);
      first = 1'b0;
    end
    if (!end_on_byte)
      queue_req(byte_t'($urandom_range(0, 255)), 1'b0, 1'b1, first);
  endfunction

  // Message lengths: mostly short, a good share around the point where the
  // length field no longer fits in the current block (55 and 56 bytes) and
  // around the block size, and a few of about two blocks (112 to 130 bytes).
  function automatic int unsigned pick_length();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick <= 5)
      return $urandom_range(0, 12);
    else if (pick <= 8)
      return $urandom_range(52, 72);
    else
      return $urandom_range(112, 130);
  endfunction

  // --------------------------------------------------------------------------
  // Sequencing of the run
  // --------------------------------------------------------------------------

  initial begin
    int unsigned msg_count;
    // Every input known from time zero; the clocked processes take over
    // from the first edge.
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.data_byte      = '0;
    in_ch.byte_present   = 1'b0;
    in_ch.end_of_message = 1'b0;
    out_ch.ready         = 1'b0;

    mismatches      = 0;
    digests_checked = 0;
    msg_reqs_queued = 0;
    send_gap_left   = 0;
    recv_gap_left   = 0;
    long_stall_left = 0;
    long_stall_done = 1'b0;
    sha_restart();

    // Directed part. The empty message: a lone end request with no byte.
    queue_req(8'h00, 1'b0, 1'b1, 1'b0);
    // The classic three-byte message, closed on its last byte.
    queue_req(8'h61, 1'b1, 1'b0, 1'b0);
    queue_req(8'h62, 1'b1, 1'b0, 1'b0);
    queue_req(8'h63, 1'b1, 1'b1, 1'b0);
    // Byte extremes with an ignored request between them, closed by an end
    // request that carries no byte.
    queue_req(8'h00, 1'b1, 1'b0, 1'b0);
    queue_req(8'hff, 1'b0, 1'b0, 1'b0);
    queue_req(8'hff, 1'b1, 1'b0, 1'b0);
    queue_req(8'h00, 1'b0, 1'b1, 1'b0);
    // A single all-ones byte together with the end flag.
    queue_req(8'hff, 1'b1, 1'b1, 1'b0);
    // A single zero byte, then an end request whose unused data is noise.
    queue_req(8'h00, 1'b1, 1'b0, 1'b0);
    queue_req(8'h5a, 1'b0, 1'b1, 1'b0);

    // Random part. The third random message waits for the pipeline to drain,
    // and so does an occasional later one.
    msg_count = 0;
    while (msg_reqs_queued < MESSAGE_REQS) begin
      queue_message(pick_length(), (msg_count == 2) || ($urandom_range(0, 7) == 0));
      msg_count++;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || in_ch.valid || digest_words_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hard limit on the run, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Byte channel driver
  // --------------------------------------------------------------------------
  // An accepted request is handed to the model on the edge that takes it. A
  // request that is not yet taken is held as it stands; otherwise the next one
  // is offered, unless an idle burst is running, or the head of the queue must
  // wait for all outstanding words to come back.
  always @(posedge clk) begin
    logic offer_next;
    if (!rst_n) begin
      in_ch.valid          <= 1'b0;
      in_ch.data_byte      <= '0;
      in_ch.byte_present   <= 1'b0;
      in_ch.end_of_message <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        sha_absorb_request(req_on_wire);
      if (!in_ch.valid || in_ch.ready) begin
        offer_next = 1'b0;
        if (send_gap_left > 0) begin
          send_gap_left--;
        end else if (pending_reqs.size() != 0) begin
          if (pending_reqs[0].hold_for_drain && digest_words_due.size() != 0) begin
            offer_next = 1'b0;
          end else if (pending_reqs.size() > TAIL_REQS && $urandom_range(0, 7) == 0) begin
            // Idle burst that starts with this cycle.
            send_gap_left = $urandom_range(0, 10);
          end else begin
            req_on_wire = pending_reqs.pop_front();
            offer_next  = 1'b1;
          end
        end
        in_ch.valid <= offer_next;
        if (offer_next) begin
          in_ch.data_byte      <= req_on_wire.data_byte;
          in_ch.byte_present   <= req_on_wire.byte_present;
          in_ch.end_of_message <= req_on_wire.end_of_message;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Digest channel receiver
  // --------------------------------------------------------------------------
  // Ready idles in short random bursts. Once, as a digest begins to come out
  // after the first two, ready is held low for a long stretch while the
  // sender keeps offering bytes, so that the block backs up and stalls its
  // byte channel.
  always @(posedge clk) begin
    logic take_next;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      take_next = 1'b1;
      if (long_stall_left > 0) begin
        long_stall_left--;
        take_next = 1'b0;
      end else if (!long_stall_done && out_ch.valid && digests_checked >= 2) begin
        long_stall_done = 1'b1;
        long_stall_left = LONG_STALL_CYCLES - 1;
        take_next       = 1'b0;
      end else if (recv_gap_left > 0) begin
        recv_gap_left--;
        take_next = 1'b0;
      end else if (pending_reqs.size() > TAIL_REQS && $urandom_range(0, 5) == 0) begin
        recv_gap_left = $urandom_range(0, 10);
        take_next     = 1'b0;
      end
      out_ch.ready <= take_next;
    end
  end

  // --------------------------------------------------------------------------
  // Digest word checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    digest_exp_t due;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (digest_words_due.size() == 0) begin
        $display("%0t: unexpected digest word: actual word %08h index %0d last %0b",
                 $time, out_ch.digest_word, out_ch.word_index, out_ch.last_word);
        mismatches++;
      end else begin
        due = digest_words_due.pop_front();
        if (out_ch.digest_word !== due.digest_word) begin
          $display("%0t: digest_word mismatch: expected %08h actual %08h",
                   $time, due.digest_word, out_ch.digest_word);
          mismatches++;
        end
        if (out_ch.word_index !== due.word_index) begin
          $display("%0t: word_index mismatch: expected %0d actual %0d",
                   $time, due.word_index, out_ch.word_index);
          mismatches++;
        end
        if (out_ch.last_word !== due.last_word) begin
          $display("%0t: last_word mismatch: expected %0b actual %0b",
                   $time, due.last_word, out_ch.last_word);
          mismatches++;
        end
        if (due.last_word)
          digests_checked++;
      end
    end
  end

endmodule

[sha256_byte_stream_hasher.f]
rtl/shabsh_pkg.sv
rtl/shabsh_if.sv
rtl/shabsh_round.sv
rtl/sha256_byte_stream_hasher.sv
tb/sha256_byte_stream_hasher_tb.sv
